// ===== hdl/btg_pkg.sv =====
package btg_pkg;

   localparam int PHASE_BITS_DEF  = 16;
   localparam int SAMPLE_BITS_DEF = 16;

   localparam int CSR_ADDR_W = 5;
   localparam int CSR_DATA_W = 32;
   localparam int REG_IDX_W  = 3;

   localparam logic [REG_IDX_W-1:0] REG_PHASE_STEP     = 3'd0;
   localparam logic [REG_IDX_W-1:0] REG_PEAK_AMPLITUDE = 3'd1;
   localparam logic [REG_IDX_W-1:0] REG_BUFFER_LENGTH  = 3'd2;
   localparam logic [REG_IDX_W-1:0] REG_WHOLE_PASSES   = 3'd3;
   localparam logic [REG_IDX_W-1:0] REG_TAIL_LENGTH    = 3'd4;

   localparam int STEP_W = 15;
   localparam int AMP_W  = 15;
   localparam int LEN_W  = 16;
   localparam int PASS_W = 8;

   localparam logic [STEP_W-1:0] PHASE_STEP_RST     = 15'd2972;
   localparam logic [AMP_W-1:0]  PEAK_AMPLITUDE_RST = 15'd10000;
   localparam logic [LEN_W-1:0]  BUFFER_LENGTH_RST  = 16'd22050;
   localparam logic [PASS_W-1:0] WHOLE_PASSES_RST   = 8'd0;
   localparam logic [LEN_W-1:0]  TAIL_LENGTH_RST    = 16'd22050;

   localparam int MUL_W  = 32;
   localparam int PROD_W = 64;

   localparam int               Q15_SHIFT  = 15;
   localparam logic [15:0]      Q15_ONE    = 16'd32768;
   localparam int               CORR_COEF  = 7373;
   localparam int               CORR_ROUND = 16384;

   localparam int RISE_LEN   = 100;
   localparam int FALL_LEN   = 1000;
   localparam int RISE_SHIFT = 29;
   localparam int RISE_RECIP = 5368710;
   localparam int FALL_SHIFT = 35;
   localparam int FALL_RECIP = 34359739;

   typedef struct packed {
      logic [STEP_W-1:0] phase_step;
      logic [AMP_W-1:0]  peak_amplitude;
      logic [LEN_W-1:0]  buffer_length;
      logic [PASS_W-1:0] whole_passes;
      logic [LEN_W-1:0]  tail_length;
   } cfg_type;

   typedef struct packed {
      logic sounding;
      logic last;
   } job_ctl_type;

   function automatic logic [LEN_W-1:0] eff_buf(input logic [LEN_W-1:0] len);
      return (len == '0) ? LEN_W'(1) : len;
   endfunction

endpackage

// ===== hdl/beep_tone_generator.sv =====
// Each transfer in gives one sample transfer out, registered at the output once the
// output register has room. A sounding item runs seven sequencer steps, all but ST_S on
// the shared multiplier, and one to hand its sample over; an idle tick only hands over its
// zero sample, and no new item is taken until the last one has handed its sample over.
// The result register lets the next item start while a sample waits to be taken.
// Reset is synchronous and active high; it loads the register defaults and
// leaves the generator silent at sample zero.
module beep_tone_generator import btg_pkg::*; #(
   parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
   parameter int PHASE_BITS  = PHASE_BITS_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic                   req_start_req,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic [SAMPLE_BITS-1:0] rsp_sample,
   output logic                   rsp_valid_res,
   output logic                   rsp_last,
   input  logic                   csr_psel,
   input  logic                   csr_penable,
   input  logic                   csr_pwrite,
   input  logic [CSR_ADDR_W-1:0]  csr_paddr,
   input  logic [CSR_DATA_W-1:0]  csr_pwdata,
   output logic [CSR_DATA_W-1:0]  csr_prdata,
   output logic                   csr_pready
);

   cfg_type               cfg;
   job_ctl_type           job_ctl;
   logic [PHASE_BITS-1:0] job_phase;
   logic [LEN_W-1:0]      job_index;
   logic                  accept;
   logic                  seq_idle;
   logic                  res_valid;
   logic                  res_take;
   job_ctl_type           res_ctl;
   logic [SAMPLE_BITS-1:0] res_sample;

   logic                   rsp_valid_ff, rsp_valid_in;
   logic [SAMPLE_BITS-1:0] rsp_sample_ff;
   logic                   rsp_valid_res_ff;
   logic                   rsp_last_ff;

   btg_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   btg_beep #(
      .PHASE_BITS (PHASE_BITS)
   ) u_beep (
      .clock     (clock),
      .reset     (reset),
      .step      (accept),
      .start_req (req_start_req),
      .cfg       (cfg),
      .job_ctl   (job_ctl),
      .job_phase (job_phase),
      .job_index (job_index)
   );

   btg_seq #(
      .PHASE_BITS  (PHASE_BITS),
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_seq (
      .clock      (clock),
      .reset      (reset),
      .start      (accept),
      .job_ctl    (job_ctl),
      .job_phase  (job_phase),
      .job_index  (job_index),
      .cfg        (cfg),
      .res_take   (res_take),
      .idle       (seq_idle),
      .res_valid  (res_valid),
      .res_ctl    (res_ctl),
      .res_sample (res_sample)
   );

   assign req_ready    = seq_idle;
   assign accept       = req_valid & req_ready;
   assign res_take     = res_valid & (!rsp_valid_ff | rsp_ready);
   assign rsp_valid_in = res_take | (rsp_valid_ff & !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (res_take) begin
         rsp_sample_ff    <= res_sample;
         rsp_valid_res_ff <= res_ctl.sounding;
         rsp_last_ff      <= res_ctl.last;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_sample    = rsp_sample_ff;
   assign rsp_valid_res = rsp_valid_res_ff;
   assign rsp_last      = rsp_last_ff;

   // A silent tick carries an all-zero sample and never marks the end.
   a_idle_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_valid_res |-> rsp_sample == '0 && !rsp_last)
      else $error("silent tick carries a non-zero sample or end mark");

   a_last_sounding: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_last |-> rsp_valid_res)
      else $error("end mark on a silent tick");

   a_busy_after_transfer: assert property (@(posedge clock) disable iff (reset)
      accept |=> !req_ready)
      else $error("new transfer taken while the previous one is in work");

   a_take_needs_room: assert property (@(posedge clock) disable iff (reset)
      res_take |-> !rsp_valid_ff || rsp_ready)
      else $error("result register overwritten before transfer");

endmodule

// ===== hdl/btg_csr.sv =====
module btg_csr import btg_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready,
   output cfg_type               cfg
);

   cfg_type               cfg_ff;
   cfg_type               cfg_in;
   logic [REG_IDX_W-1:0]  reg_idx;
   logic                  wr_en;

   assign reg_idx    = csr_paddr[CSR_ADDR_W-1:2];
   assign wr_en      = csr_psel & csr_penable & csr_pwrite;
   assign csr_pready = 1'b1;
   assign cfg        = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (reg_idx)
            REG_PHASE_STEP:     cfg_in.phase_step     = csr_pwdata[STEP_W-1:0];
            REG_PEAK_AMPLITUDE: cfg_in.peak_amplitude = csr_pwdata[AMP_W-1:0];
            REG_BUFFER_LENGTH:  cfg_in.buffer_length  = csr_pwdata[LEN_W-1:0];
            REG_WHOLE_PASSES:   cfg_in.whole_passes   = csr_pwdata[PASS_W-1:0];
            REG_TAIL_LENGTH:    cfg_in.tail_length    = csr_pwdata[LEN_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (reg_idx)
         REG_PHASE_STEP:     csr_prdata = CSR_DATA_W'(cfg_ff.phase_step);
         REG_PEAK_AMPLITUDE: csr_prdata = CSR_DATA_W'(cfg_ff.peak_amplitude);
         REG_BUFFER_LENGTH:  csr_prdata = CSR_DATA_W'(cfg_ff.buffer_length);
         REG_WHOLE_PASSES:   csr_prdata = CSR_DATA_W'(cfg_ff.whole_passes);
         REG_TAIL_LENGTH:    csr_prdata = CSR_DATA_W'(cfg_ff.tail_length);
         default:            csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.phase_step     <= PHASE_STEP_RST;
         cfg_ff.peak_amplitude <= PEAK_AMPLITUDE_RST;
         cfg_ff.buffer_length  <= BUFFER_LENGTH_RST;
         cfg_ff.whole_passes   <= WHOLE_PASSES_RST;
         cfg_ff.tail_length    <= TAIL_LENGTH_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

// ===== hdl/btg_beep.sv =====
module btg_beep import btg_pkg::*; #(
   parameter int PHASE_BITS = PHASE_BITS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  step,
   input  logic                  start_req,
   input  cfg_type               cfg,
   output job_ctl_type           job_ctl,
   output logic [PHASE_BITS-1:0] job_phase,
   output logic [LEN_W-1:0]      job_index
);

   localparam int STEP_EXT_W = PHASE_BITS + STEP_W;

   logic [LEN_W-1:0]      sample_index_ff, sample_index_in;
   logic [PASS_W-1:0]     pass_counter_ff, pass_counter_in;
   logic [PHASE_BITS-1:0] phase_accum_ff,  phase_accum_in;
   logic                  sounding_ff,     sounding_in;
   logic                  in_tail_pass_ff, in_tail_pass_in;

   logic [LEN_W-1:0]      idx0;
   logic [PASS_W-1:0]     pc0;
   logic [PHASE_BITS-1:0] ph0;
   logic                  tail0;
   logic                  snd0;
   logic [LEN_W-1:0]      len;
   logic [LEN_W:0]        idx_inc;
   logic                  wrap;
   logic [PASS_W-1:0]     pc_inc;
   logic                  fin;
   logic [STEP_EXT_W-1:0] step_ext;
   logic [PHASE_BITS-1:0] step_p;

   assign step_ext = STEP_EXT_W'(cfg.phase_step);
   assign step_p   = step_ext[PHASE_BITS-1:0];

   always_comb begin
      idx0  = start_req ? '0 : sample_index_ff;
      pc0   = start_req ? '0 : pass_counter_ff;
      ph0   = start_req ? '0 : phase_accum_ff;
      tail0 = start_req ? (cfg.whole_passes == '0) : in_tail_pass_ff;
      snd0  = start_req ? !(tail0 && (cfg.tail_length == '0)) : sounding_ff;

      len     = tail0 ? cfg.tail_length : eff_buf(cfg.buffer_length);
      idx_inc = {1'b0, idx0} + (LEN_W+1)'(1);
      wrap    = idx_inc >= {1'b0, len};
      pc_inc  = pc0 + PASS_W'(1);

      sample_index_in = idx0;
      pass_counter_in = pc0;
      phase_accum_in  = ph0;
      in_tail_pass_in = tail0;
      sounding_in     = snd0;
      fin             = 1'b0;

      if (snd0) begin
         if (wrap) begin
            sample_index_in = '0;
            phase_accum_in  = '0;
            if (tail0) begin
               fin = 1'b1;
            end else begin
               pass_counter_in = pc_inc;
               if (pc_inc >= cfg.whole_passes) begin
                  if (cfg.tail_length == '0) begin
                     fin = 1'b1;
                  end else begin
                     in_tail_pass_in = 1'b1;
                  end
               end
            end
         end else begin
            sample_index_in = idx_inc[LEN_W-1:0];
            phase_accum_in  = ph0 + step_p;
         end
         if (fin) begin
            sounding_in     = 1'b0;
            in_tail_pass_in = 1'b0;
            pass_counter_in = '0;
         end
      end
   end

   assign job_ctl.sounding = snd0;
   assign job_ctl.last     = fin;
   assign job_phase        = ph0;
   assign job_index        = idx0;

   always_ff @(posedge clock) begin
      if (reset) begin
         sample_index_ff <= '0;
         pass_counter_ff <= '0;
         phase_accum_ff  <= '0;
         sounding_ff     <= 1'b0;
         in_tail_pass_ff <= 1'b0;
      end else if (step) begin
         sample_index_ff <= sample_index_in;
         pass_counter_ff <= pass_counter_in;
         phase_accum_ff  <= phase_accum_in;
         sounding_ff     <= sounding_in;
         in_tail_pass_ff <= in_tail_pass_in;
      end
   end

endmodule

// ===== hdl/btg_mul.sv =====
module btg_mul import btg_pkg::*; (
   input  logic              clock,
   input  logic              en,
   input  logic [MUL_W-1:0]  op_a,
   input  logic [MUL_W-1:0]  op_b,
   output logic [PROD_W-1:0] prod
);

   logic [PROD_W-1:0] prod_ff;
   logic [PROD_W-1:0] prod_in;

   assign prod_in = PROD_W'(op_a) * PROD_W'(op_b);
   assign prod    = prod_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         prod_ff <= prod_in;
      end
   end

endmodule

// ===== hdl/btg_seq.sv =====
module btg_seq import btg_pkg::*; #(
   parameter int PHASE_BITS  = PHASE_BITS_DEF,
   parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   input  job_ctl_type            job_ctl,
   input  logic [PHASE_BITS-1:0]  job_phase,
   input  logic [LEN_W-1:0]       job_index,
   input  cfg_type                cfg,
   input  logic                   res_take,
   output logic                   idle,
   output logic                   res_valid,
   output job_ctl_type            res_ctl,
   output logic [SAMPLE_BITS-1:0] res_sample
);

   localparam logic [3:0] ST_IDLE = 4'd0;
   localparam logic [3:0] ST_M    = 4'd1;
   localparam logic [3:0] ST_E    = 4'd2;
   localparam logic [3:0] ST_T    = 4'd3;
   localparam logic [3:0] ST_Q    = 4'd4;
   localparam logic [3:0] ST_C    = 4'd5;
   localparam logic [3:0] ST_S    = 4'd6;
   localparam logic [3:0] ST_O    = 4'd7;
   localparam logic [3:0] ST_N    = 4'd8;

   localparam logic [1:0] ENV_RISE = 2'd0;
   localparam logic [1:0] ENV_FALL = 2'd1;
   localparam logic [1:0] ENV_ZERO = 2'd2;
   localparam logic [1:0] ENV_FLAT = 2'd3;

   localparam int                    M_SHIFT  = 2 * PHASE_BITS - 19;
   localparam logic [PHASE_BITS-1:0] HALF     = PHASE_BITS'(1) << (PHASE_BITS - 1);
   localparam logic [31:0]           AMP_CAP  = 32'((1 << (SAMPLE_BITS - 1)) - 1);
   localparam int                    E_W      = 25;
   localparam int                    T_W      = 14;
   localparam int                    CORR_W   = 11;
   localparam int                    SUM_W    = 26;
   localparam int                    MAG_EXT_W = SAMPLE_BITS + AMP_W;

   logic [3:0]            state_ff, state_in;
   job_ctl_type           ctl_ff;
   logic [PHASE_BITS-1:0] phase_ff;
   logic [LEN_W-1:0]      index_ff;
   logic [1:0]            cls_ff, cls_in;
   logic [LEN_W-1:0]      efac_ff, efac_in;
   logic [15:0]           m_ff;
   logic [E_W-1:0]        e_ff;
   logic [T_W-1:0]        t_ff;
   logic [AMP_W-1:0]      env_ff, env_in;
   logic [15:0]           s_ff;

   logic                  mul_en;
   logic [MUL_W-1:0]      op_a, op_b;
   logic [PROD_W-1:0]     prod;

   logic [PHASE_BITS-1:0] mag;
   logic [AMP_W-1:0]      amp;
   logic [LEN_W-1:0]      span;
   logic signed [LEN_W:0] r;
   logic [LEN_W:0]        fall_fac;
   logic [AMP_W-1:0]      q;
   logic [SUM_W-1:0]      corr_sum;
   logic [CORR_W-1:0]     corr;
   logic [AMP_W-1:0]      out_mag;
   logic [MAG_EXT_W-1:0]  out_ext;
   logic [SAMPLE_BITS-1:0] out_s;

   btg_mul u_mul (
      .clock (clock),
      .en    (mul_en),
      .op_a  (op_a),
      .op_b  (op_b),
      .prod  (prod)
   );

   assign mag  = phase_ff[PHASE_BITS-1] ? (~phase_ff + PHASE_BITS'(1)) : phase_ff;
   assign amp  = (32'(cfg.peak_amplitude) < AMP_CAP) ? cfg.peak_amplitude
                                                     : AMP_CAP[AMP_W-1:0];
   assign span = (cfg.whole_passes == '0) ? cfg.tail_length : eff_buf(cfg.buffer_length);
   assign r    = signed'({1'b0, span}) - signed'({1'b0, index_ff});
   assign fall_fac = (LEN_W+1)'(FALL_LEN) - unsigned'(r);

   always_comb begin
      cls_in  = ENV_FLAT;
      efac_in = '0;
      if (index_ff < LEN_W'(RISE_LEN)) begin
         cls_in  = ENV_RISE;
         efac_in = index_ff;
      end else if (r < signed'((LEN_W+1)'(FALL_LEN))) begin
         if (r <= 0) begin
            cls_in = ENV_ZERO;
         end else begin
            cls_in  = ENV_FALL;
            efac_in = fall_fac[LEN_W-1:0];
         end
      end
   end

   always_comb begin
      case (cls_ff)
         ENV_RISE: q = prod[RISE_SHIFT +: AMP_W];
         default:  q = prod[FALL_SHIFT +: AMP_W];
      endcase
      case (cls_ff)
         ENV_RISE: env_in = q;
         ENV_FALL: env_in = amp - q;
         ENV_ZERO: env_in = '0;
         default:  env_in = amp;
      endcase
   end

   assign corr_sum = prod[SUM_W-1:0] + SUM_W'(CORR_ROUND);
   assign corr     = corr_sum[SUM_W-1:Q15_SHIFT];
   assign out_mag  = prod[Q15_SHIFT +: AMP_W];
   assign out_ext  = MAG_EXT_W'(out_mag);
   assign out_s    = phase_ff[PHASE_BITS-1] ? (~out_ext[SAMPLE_BITS-1:0] + SAMPLE_BITS'(1))
                                            : out_ext[SAMPLE_BITS-1:0];

   always_comb begin
      mul_en = 1'b1;
      op_a   = '0;
      op_b   = '0;
      case (state_ff)
         ST_M: begin
            op_a = MUL_W'(mag);
            op_b = MUL_W'(HALF - mag);
         end
         ST_E: begin
            op_a = MUL_W'(amp);
            op_b = MUL_W'(efac_ff);
         end
         ST_T: begin
            op_a = MUL_W'(m_ff);
            op_b = MUL_W'(Q15_ONE - m_ff);
         end
         ST_Q: begin
            op_a = MUL_W'(e_ff);
            op_b = (cls_ff == ENV_RISE) ? MUL_W'(RISE_RECIP) : MUL_W'(FALL_RECIP);
         end
         ST_C: begin
            op_a = MUL_W'(t_ff);
            op_b = MUL_W'(CORR_COEF);
         end
         ST_O: begin
            op_a = MUL_W'(s_ff);
            op_b = MUL_W'(env_ff);
         end
         default: mul_en = 1'b0;
      endcase
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               state_in = job_ctl.sounding ? ST_M : ST_N;
            end
         end
         ST_M: state_in = ST_E;
         ST_E: state_in = ST_T;
         ST_T: state_in = ST_Q;
         ST_Q: state_in = ST_C;
         ST_C: state_in = ST_S;
         ST_S: state_in = ST_O;
         ST_O: state_in = ST_N;
         ST_N: begin
            if (res_take) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         ctl_ff   <= '0;
      end else begin
         state_ff <= state_in;
         if (state_ff == ST_IDLE && start) begin
            ctl_ff <= job_ctl;
         end
      end
   end

   always_ff @(posedge clock) begin
      case (state_ff)
         ST_IDLE: begin
            phase_ff <= job_phase;
            index_ff <= job_index;
         end
         ST_M: begin
            cls_ff  <= cls_in;
            efac_ff <= efac_in;
         end
         ST_E: m_ff   <= prod[M_SHIFT +: 16];
         ST_T: e_ff   <= prod[E_W-1:0];
         ST_Q: t_ff   <= prod[Q15_SHIFT +: T_W];
         ST_C: env_ff <= env_in;
         ST_S: s_ff   <= m_ff - 16'(corr);
         default: ;
      endcase
   end

   assign idle       = (state_ff == ST_IDLE);
   assign res_valid  = (state_ff == ST_N);
   assign res_ctl    = ctl_ff;
   assign res_sample = ctl_ff.sounding ? out_s : '0;

endmodule
